// ===== rtl/core/ppid_pkg.sv =====
package ppid_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int GAIN_FRAC_BITS = 16;

    localparam int GAIN_W     = 32;
    localparam int LIMIT_W    = 31;
    localparam int INTEG_W    = 32;
    localparam int DRIVE_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int ERR_W      = SAMPLE_WIDTH + 1;
    localparam int DELTA_W    = SAMPLE_WIDTH + 2;
    localparam int P_PROD_W   = ERR_W + GAIN_W;
    localparam int D_PROD_W   = DELTA_W + GAIN_W;
    localparam int P_TERM_W   = P_PROD_W - GAIN_FRAC_BITS;
    localparam int D_TERM_W   = D_PROD_W - GAIN_FRAC_BITS;
    localparam int I_ACC_W    = ((P_TERM_W > INTEG_W) ? P_TERM_W : INTEG_W) + 1;
    localparam int PD_W       = D_TERM_W + 1;
    localparam int TOT_W      = ((PD_W > INTEG_W) ? PD_W : INTEG_W) + 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_STEP  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN  = 3'd0,
        REG_INTEG_GAIN = 3'd1,
        REG_DERIV_GAIN = 3'd2,
        REG_OUT_LIMIT  = 3'd3,
        REG_INTEG_LIM  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic                      clear;
        logic signed [ERR_W-1:0]   err;
        logic signed [DELTA_W-1:0] delta;
    } t_item;

    typedef struct packed {
        logic signed [GAIN_W-1:0] prop_gain;
        logic signed [GAIN_W-1:0] integ_gain;
        logic signed [GAIN_W-1:0] deriv_gain;
        logic [LIMIT_W-1:0]       out_limit;
        logic [LIMIT_W-1:0]       integ_limit;
    } t_gains;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== rtl/core/ppid_front.sv =====
module ppid_front (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    output logic                                        o_stall,
    input  logic                                        i_command,
    input  logic signed [ppid_pkg::SAMPLE_WIDTH-1:0]    i_measured,
    input  logic signed [ppid_pkg::SAMPLE_WIDTH-1:0]    i_target,
    output logic                                        o_valid,
    input  logic                                        i_ready,
    output ppid_pkg::t_item                             o_item
);
    import ppid_pkg::*;

    logic                      r_valid;
    t_item                     r_item;
    t_item                     n_item;
    logic signed [ERR_W-1:0]   r_prev_err;
    logic signed [ERR_W-1:0]   err;
    logic                      advance;
    logic                      accept;

    assign advance = !r_valid || i_ready;
    assign accept  = i_valid && advance;
    assign o_stall = !advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    assign err = ERR_W'(i_target) - ERR_W'(i_measured);

    // delta against the last step's error; a clear zeroes the history
    always_comb begin
        if (i_command == CMD_CLEAR) begin
            n_item.clear = 1'b1;
            n_item.err   = '0;
            n_item.delta = '0;
        end else begin
            n_item.clear = 1'b0;
            n_item.err   = err;
            n_item.delta = DELTA_W'(err) - DELTA_W'(r_prev_err);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_prev_err <= '0;
        end else begin
            if (advance) begin
                r_valid <= i_valid;
            end
            if (accept) begin
                r_prev_err <= n_item.err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== rtl/core/ppid_queue.sv =====
module ppid_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ppid_pkg::t_item   i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output ppid_pkg::t_item   o_item,
    output ppid_pkg::t_q_stat o_stat
);
    import ppid_pkg::*;

    t_item               r_mem [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;
    logic                full;
    logic                empty;
    logic                push;
    logic                pop;

    assign full  = (r_count == Q_CNT_W'(QUEUE_DEPTH));
    assign empty = (r_count == '0);
    assign push  = i_valid && !full;
    assign pop   = !empty && i_ready;

    assign o_ready      = !full;
    assign o_valid      = !empty;
    assign o_item       = r_mem[r_rd_ptr];
    assign o_stat.full  = full;
    assign o_stat.empty = empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== rtl/core/ppid_back.sv =====
module ppid_back (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  ppid_pkg::t_item                        i_item,
    input  ppid_pkg::t_gains                       i_gains,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [ppid_pkg::DRIVE_W-1:0]    o_drive
);
    import ppid_pkg::*;

    // stage 1: products
    logic                       r_s1_valid;
    logic                       r_s1_clear;
    logic signed [P_TERM_W-1:0] r_p_term;
    logic signed [P_TERM_W-1:0] r_i_term;
    logic signed [D_TERM_W-1:0] r_d_term;

    // stage 2: integral and P+D
    logic                       r_s2_valid;
    logic signed [INTEG_W-1:0]  r_integ;
    logic signed [PD_W-1:0]     r_pd;

    // output register
    logic                       r_out_valid;
    logic signed [DRIVE_W-1:0]  r_drive;

    logic                       out_adv;
    logic                       s2_adv;
    logic                       s1_adv;

    logic signed [P_PROD_W-1:0] p_prod;
    logic signed [P_PROD_W-1:0] i_prod;
    logic signed [D_PROD_W-1:0] d_prod;

    logic signed [I_ACC_W-1:0]  acc;
    logic signed [I_ACC_W-1:0]  ilim;
    logic signed [I_ACC_W-1:0]  n_integ_wide;
    logic signed [INTEG_W-1:0]  n_integ;

    logic signed [TOT_W-1:0]    tot;
    logic signed [TOT_W-1:0]    olim;
    logic signed [TOT_W-1:0]    n_drive_wide;
    logic signed [DRIVE_W-1:0]  n_drive;

    assign out_adv = !r_out_valid || !i_stall;
    assign s2_adv  = !r_s2_valid || out_adv;
    assign s1_adv  = !r_s1_valid || s2_adv;
    assign o_ready = s1_adv;
    assign o_valid = r_out_valid;
    assign o_drive = r_drive;

    assign p_prod = $signed(i_item.err) * $signed(i_gains.prop_gain);
    assign i_prod = $signed(i_item.err) * $signed(i_gains.integ_gain);
    assign d_prod = $signed(i_item.delta) * $signed(i_gains.deriv_gain);

    // integral update: the only loop that closes through state each item
    always_comb begin
        acc  = I_ACC_W'(r_integ) + I_ACC_W'(r_i_term);
        ilim = $signed(I_ACC_W'(i_gains.integ_limit));
        if (acc > ilim) begin
            n_integ_wide = ilim;
        end else if (acc < -ilim) begin
            n_integ_wide = -ilim;
        end else begin
            n_integ_wide = acc;
        end
        n_integ = n_integ_wide[INTEG_W-1:0];
    end

    always_comb begin
        tot  = TOT_W'(r_pd) + TOT_W'(r_integ);
        olim = $signed(TOT_W'(i_gains.out_limit));
        if (tot > olim) begin
            n_drive_wide = olim;
        end else if (tot < -olim) begin
            n_drive_wide = -olim;
        end else begin
            n_drive_wide = tot;
        end
        n_drive = n_drive_wide[DRIVE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_integ     <= '0;
        end else begin
            if (s1_adv) begin
                r_s1_valid <= i_valid;
            end
            if (s2_adv) begin
                r_s2_valid <= r_s1_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_s2_valid;
            end
            if (r_s1_valid && s2_adv) begin
                r_integ <= r_s1_clear ? '0 : n_integ;
            end
        end
    end

    // floor shift: keep the upper product bits
    always_ff @(posedge i_clk) begin
        if (i_valid && s1_adv) begin
            r_s1_clear <= i_item.clear;
            r_p_term   <= p_prod[P_PROD_W-1:GAIN_FRAC_BITS];
            r_i_term   <= i_prod[P_PROD_W-1:GAIN_FRAC_BITS];
            r_d_term   <= d_prod[D_PROD_W-1:GAIN_FRAC_BITS];
        end
        if (r_s1_valid && s2_adv) begin
            r_pd <= r_s1_clear ? '0 : (PD_W'(r_p_term) + PD_W'(r_d_term));
        end
        if (r_s2_valid && out_adv) begin
            r_drive <= n_drive;
        end
    end

endmodule

// ===== rtl/core/positional_pid_controller_core.sv =====
// Channel   Direction  Handshake                 Payload
// in        in         i_in_valid / o_in_stall   i_command, i_measured, i_target
// out       out        o_out_valid / i_out_stall o_drive
// cfg       in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// One item per cycle sustained when the output does not stall; the front
// register loads at the accepting edge, then the item passes the queue, multiply
// stage, integral stage and output register before drive is valid.
// The integral add and clamp closes on itself once per item.
// Synchronous active-low reset clears gains, limits, integral and error history.
// An output stall backs up the back pipeline, then the queue, then o_in_stall.
module positional_pid_controller_core (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_in_valid,
    output logic                                        o_in_stall,
    input  logic                                        i_command,
    input  logic signed [ppid_pkg::SAMPLE_WIDTH-1:0]    i_measured,
    input  logic signed [ppid_pkg::SAMPLE_WIDTH-1:0]    i_target,
    output logic                                        o_out_valid,
    input  logic                                        i_out_stall,
    output logic signed [ppid_pkg::DRIVE_W-1:0]         o_drive,
    input  logic                                        i_cfg_we,
    input  logic [ppid_pkg::CFG_IDX_W-1:0]              i_cfg_index,
    input  logic [ppid_pkg::CFG_DATA_W-1:0]             i_cfg_data
);
    import ppid_pkg::*;

    t_gains   r_gains;
    logic     f_valid;
    t_item    f_item;
    logic     q_ready;
    logic     q_valid;
    t_item    q_item;
    t_q_stat  q_stat;
    logic     b_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_PROP_GAIN:  r_gains.prop_gain   <= i_cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN: r_gains.integ_gain  <= i_cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN: r_gains.deriv_gain  <= i_cfg_data[GAIN_W-1:0];
                REG_OUT_LIMIT:  r_gains.out_limit   <= i_cfg_data[LIMIT_W-1:0];
                REG_INTEG_LIM:  r_gains.integ_limit <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    ppid_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_stall    (o_in_stall),
        .i_command  (i_command),
        .i_measured (i_measured),
        .i_target   (i_target),
        .o_valid    (f_valid),
        .i_ready    (q_ready),
        .o_item     (f_item)
    );

    ppid_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (q_ready),
        .i_item  (f_item),
        .o_valid (q_valid),
        .i_ready (b_ready),
        .o_item  (q_item),
        .o_stat  (q_stat)
    );

    ppid_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (b_ready),
        .i_item  (q_item),
        .i_gains (r_gains),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_drive (o_drive)
    );

    // a held front item with a full queue must stall the input
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (f_valid && q_stat.full) |-> o_in_stall)
        else $error("front did not stall on full queue");

    // the input stalls only while the front holds an item
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> f_valid)
        else $error("input stalled with empty front");

    // a full queue that the back does not drain stays full
    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_stat.full && !b_ready) |=> q_stat.full)
        else $error("queue lost an item while back was stalled");

    a_q_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty) && (q_valid == !q_stat.empty))
        else $error("queue status inconsistent");

endmodule
